/* hw/rtl/rpid_pkg.sv */
// Package for the three-axis rate PID block: fixed widths, gain reset values,
// multiplier operand codes and the controller/datapath command and status structs.
// No dependencies.
package rpid_pkg;

    localparam int GAIN_W    = 24;   // Q8.16 gains, also the multiplier chunk width
    localparam int DT_W      = 20;   // Q0.20 step period
    localparam int DT_FRAC   = 20;
    localparam int GAIN_FRAC = 16;
    localparam int NUM_GAINS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CLAMP_W   = 48;   // magnitude width of a clamped term
    localparam int TERM_W    = 49;   // signed clamped term / derivative
    localparam int SUM_W     = 50;   // sum of three clamped terms

    localparam logic [CLAMP_W-1:0] TERM_CLAMP = 48'h8000_0000_0000;

    localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_GAINS] = '{
        24'd39322, 24'd229376, 24'd1966, 24'd131072, 24'd0, 24'd0
    };

    typedef enum logic [1:0] {
        OP_E_DT,
        OP_E_KP,
        OP_I_KI,
        OP_D_KD
    } rpid_op_t;

    typedef struct packed {
        logic     load_in;
        logic     clear;
        logic     err;
        logic     mul_load;
        logic     mul_step;
        logic     integ;
        logic     div_load;
        logic     div_step;
        logic     deriv;
        logic     term_add;
        logic     axis_write;
        logic     publish;
        rpid_op_t op_sel;
        logic [1:0] axis;
    } rpid_cmd_t;

    typedef struct packed {
        logic out_full;
    } rpid_status_t;

endpackage

/* hw/rtl/rpid_ctrl.sv */
// Sequencer for the rate PID: walks each axis through error, integral,
// derivative division and the three gain terms. Uses rpid_pkg.
module rpid_ctrl #(
    parameter int NCH = 2,
    parameter int NW  = 54
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  rpid_pkg::rpid_status_t status,
    output rpid_pkg::rpid_cmd_t    cmd
);

    localparam int CNT_W = $clog2(NW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ERR,
        ST_ILOAD,
        ST_IMUL,
        ST_INTEG,
        ST_DIV,
        ST_DERIV,
        ST_TLOAD,
        ST_TMUL,
        ST_TADD,
        ST_AXOUT,
        ST_PUB
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       axis_reg;
    logic [1:0]       term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
            term_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= '0;
                    if (s_tvalid)
                    begin
                        state_reg <= s_tuser ? ST_CLEAR : ST_ERR;
                    end
                end
                ST_CLEAR: state_reg <= ST_PUB;
                ST_ERR:   state_reg <= ST_ILOAD;
                ST_ILOAD:
                begin
                    state_reg <= ST_IMUL;
                    cnt_reg   <= CNT_W'(NCH - 1);
                end
                ST_IMUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_INTEG;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_INTEG:
                begin
                    state_reg <= ST_DIV;
                    cnt_reg   <= CNT_W'(NW - 1);
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DERIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DERIV:
                begin
                    state_reg <= ST_TLOAD;
                    term_reg  <= '0;
                end
                ST_TLOAD:
                begin
                    state_reg <= ST_TMUL;
                    cnt_reg   <= CNT_W'(NCH - 1);
                end
                ST_TMUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_TADD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_TADD:
                begin
                    if (term_reg == 2'd2)
                    begin
                        state_reg <= ST_AXOUT;
                    end
                    else
                    begin
                        term_reg  <= term_reg + 1'b1;
                        state_reg <= ST_TLOAD;
                    end
                end
                ST_AXOUT:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_PUB;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_ERR;
                    end
                end
                ST_PUB:
                begin
                    // hold until the output register is free
                    if (!status.out_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.load_in    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.clear      = (state_reg == ST_CLEAR);
        cmd.err        = (state_reg == ST_ERR);
        cmd.mul_load   = (state_reg == ST_ILOAD) || (state_reg == ST_TLOAD);
        cmd.mul_step   = (state_reg == ST_IMUL) || (state_reg == ST_TMUL);
        cmd.integ      = (state_reg == ST_INTEG);
        cmd.div_load   = (state_reg == ST_INTEG);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.deriv      = (state_reg == ST_DERIV);
        cmd.term_add   = (state_reg == ST_TADD);
        cmd.axis_write = (state_reg == ST_AXOUT);
        cmd.publish    = (state_reg == ST_PUB) && !status.out_full;
        if (state_reg == ST_ILOAD)
        begin
            cmd.op_sel = rpid_pkg::OP_E_DT;
        end
        else
        begin
            case (term_reg)
                2'd0:    cmd.op_sel = rpid_pkg::OP_E_KP;
                2'd1:    cmd.op_sel = rpid_pkg::OP_I_KI;
                default: cmd.op_sel = rpid_pkg::OP_D_KD;
            endcase
        end
    end

endmodule

/* hw/rtl/rpid_dp.sv */
// Datapath for the rate PID: input capture, per-axis state, a shared
// chunked multiplier, a bit-serial divider and the output register. Uses rpid_pkg.
module rpid_dp #(
    parameter int RW  = 32,
    parameter int IW  = 48,
    parameter int NCH = 2,
    parameter int NW  = 54
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rpid_pkg::rpid_cmd_t                  cmd,
    output rpid_pkg::rpid_status_t               status,
    input  logic signed [RW-1:0]                 des_in  [3],
    input  logic signed [RW-1:0]                 meas_in [3],
    input  logic [rpid_pkg::DT_W-1:0]            dt_in,
    input  logic [rpid_pkg::GAIN_W-1:0]          gain    [rpid_pkg::NUM_GAINS],
    output logic signed [RW-1:0]                 out_axis [3],
    output logic                                 out_valid,
    input  logic                                 out_ready
);

    localparam int GW    = rpid_pkg::GAIN_W;
    localparam int DTW   = rpid_pkg::DT_W;
    localparam int AW    = NCH * GW;
    localparam int PW    = AW + GW;
    localparam int TW    = rpid_pkg::TERM_W;
    localparam int CW    = rpid_pkg::CLAMP_W;
    localparam int SW    = rpid_pkg::SUM_W;
    localparam int QW    = (NW > CW) ? NW : CW;

    localparam logic signed [PW+1:0] IMAX = {{(PW + 3 - IW){1'b0}}, {(IW - 1){1'b1}}};
    localparam logic signed [PW+1:0] IMIN = ~IMAX;
    localparam logic signed [SW-1:0] SMAX = {{(SW - RW + 1){1'b0}}, {(RW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    logic signed [RW-1:0] des_reg  [3];
    logic signed [RW-1:0] meas_reg [3];
    logic [DTW-1:0]       dt_reg;
    logic signed [RW:0]   e_reg;
    logic signed [RW+1:0] diff_reg;
    logic signed [RW:0]   prev_reg  [3];
    logic signed [IW-1:0] integ_reg [3];
    logic [AW-1:0]        opnd_reg;
    logic [GW-1:0]        k_reg;
    logic                 neg_reg;
    logic [PW-1:0]        acc_reg;
    logic [DTW-1:0]       rem_reg;
    logic [NW-1:0]        num_reg;
    logic [NW-1:0]        quo_reg;
    logic signed [TW-1:0] d_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [RW-1:0] res_reg [3];
    logic signed [RW-1:0] out_reg [3];
    logic                 valid_reg;

    logic signed [RW:0]   e_calc;
    logic signed [RW+1:0] diff_calc;
    logic [RW:0]          e_mag;
    logic [IW-1:0]        i_mag;
    logic [TW-1:0]        d_mag;
    logic [RW+1:0]        diff_mag;
    logic [2:0]           gbase;
    logic [AW-1:0]        opnd_sel;
    logic [GW-1:0]        k_sel;
    logic [2*GW-1:0]      prod;
    logic signed [PW:0]   sprod;
    logic signed [PW:0]   inc;
    logic signed [PW+1:0] isum;
    logic signed [IW-1:0] integ_sat;
    logic [DTW:0]         trial;
    logic                 ge;
    logic [QW-1:0]        quo_x;
    logic [CW-1:0]        q_cl;
    logic [PW:0]          t_raw;
    logic [CW-1:0]        t_cl;
    logic signed [SW-1:0] t_s;
    logic signed [SW-1:0] sum_new;
    logic signed [RW-1:0] sum_sat;

    always_comb
    begin
        e_calc    = (RW + 1)'(des_reg[cmd.axis]) - (RW + 1)'(meas_reg[cmd.axis]);
        diff_calc = (RW + 2)'(e_calc) - (RW + 2)'(prev_reg[cmd.axis]);

        e_mag    = e_reg[RW] ? (RW + 1)'(-e_reg) : (RW + 1)'(e_reg);
        i_mag    = integ_reg[cmd.axis][IW-1] ? IW'(-integ_reg[cmd.axis])
                                             : IW'(integ_reg[cmd.axis]);
        d_mag    = d_reg[TW-1] ? TW'(-d_reg) : TW'(d_reg);
        diff_mag = diff_reg[RW+1] ? (RW + 2)'(-diff_reg) : (RW + 2)'(diff_reg);

        gbase = (cmd.axis == 2'd2) ? 3'd3 : 3'd0;
        case (cmd.op_sel)
            rpid_pkg::OP_E_DT:
            begin
                opnd_sel = AW'(e_mag);
                k_sel    = GW'(dt_reg);
            end
            rpid_pkg::OP_E_KP:
            begin
                opnd_sel = AW'(e_mag);
                k_sel    = gain[gbase];
            end
            rpid_pkg::OP_I_KI:
            begin
                opnd_sel = AW'(i_mag);
                k_sel    = gain[gbase + 3'd1];
            end
            default:
            begin
                opnd_sel = AW'(d_mag);
                k_sel    = gain[gbase + 3'd2];
            end
        endcase

        prod = opnd_reg[AW-1 -: GW] * k_reg;

        // signed e*dt, rounded half up to Q.0 in rate units and added with saturation
        sprod = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        inc   = (sprod + (PW + 1)'(1 << (rpid_pkg::DT_FRAC - 1))) >>> rpid_pkg::DT_FRAC;
        isum  = (PW + 2)'(integ_reg[cmd.axis]) + (PW + 2)'(inc);
        if (isum > IMAX)
        begin
            integ_sat = IW'(IMAX);
        end
        else if (isum < IMIN)
        begin
            integ_sat = IW'(IMIN);
        end
        else
        begin
            integ_sat = IW'(isum);
        end

        trial = {rem_reg, num_reg[NW-1]};
        ge    = (trial >= {1'b0, dt_reg});

        quo_x = QW'(quo_reg);
        q_cl  = (quo_x > QW'(rpid_pkg::TERM_CLAMP)) ? rpid_pkg::TERM_CLAMP : CW'(quo_x);

        t_raw = ((PW + 1)'(acc_reg) + (neg_reg ? (PW + 1)'(32767) : (PW + 1)'(32768)))
                >> rpid_pkg::GAIN_FRAC;
        t_cl  = (t_raw > (PW + 1)'(rpid_pkg::TERM_CLAMP)) ? rpid_pkg::TERM_CLAMP : CW'(t_raw);
        t_s   = SW'({1'b0, t_cl});
        sum_new = neg_reg ? (sum_reg - t_s) : (sum_reg + t_s);

        if (sum_reg > SMAX)
        begin
            sum_sat = RW'(SMAX);
        end
        else if (sum_reg < SMIN)
        begin
            sum_sat = RW'(SMIN);
        end
        else
        begin
            sum_sat = RW'(sum_reg);
        end
    end

    // per-axis state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prev_reg[i]  <= '0;
                    integ_reg[i] <= '0;
                end
            end
            if (cmd.integ)
            begin
                integ_reg[cmd.axis] <= integ_sat;
            end
            if (cmd.axis_write)
            begin
                prev_reg[cmd.axis] <= e_reg;
            end
            if (cmd.publish)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            des_reg  <= des_in;
            meas_reg <= meas_in;
            dt_reg   <= dt_in;
        end
        if (cmd.err)
        begin
            e_reg    <= e_calc;
            diff_reg <= diff_calc;
            sum_reg  <= '0;
        end
        if (cmd.mul_load)
        begin
            opnd_reg <= opnd_sel;
            k_reg    <= k_sel;
            acc_reg  <= '0;
            case (cmd.op_sel)
                rpid_pkg::OP_E_DT, rpid_pkg::OP_E_KP: neg_reg <= e_reg[RW];
                rpid_pkg::OP_I_KI: neg_reg <= integ_reg[cmd.axis][IW-1];
                default:           neg_reg <= d_reg[TW-1];
            endcase
        end
        if (cmd.mul_step)
        begin
            acc_reg  <= (acc_reg << GW) + PW'(prod);
            opnd_reg <= opnd_reg << GW;
        end
        if (cmd.div_load)
        begin
            num_reg <= {diff_mag, {rpid_pkg::DT_FRAC{1'b0}}} + NW'(dt_reg >> 1);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? DTW'(trial - {1'b0, dt_reg}) : DTW'(trial);
            quo_reg <= {quo_reg[NW-2:0], ge};
            num_reg <= num_reg << 1;
        end
        if (cmd.deriv)
        begin
            if (dt_reg == '0)
            begin
                d_reg <= '0;
            end
            else
            begin
                d_reg <= diff_reg[RW+1] ? -$signed({1'b0, q_cl}) : $signed({1'b0, q_cl});
            end
        end
        if (cmd.term_add)
        begin
            sum_reg <= sum_new;
        end
        if (cmd.clear)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        if (cmd.axis_write)
        begin
            res_reg[cmd.axis] <= sum_sat;
        end
        if (cmd.publish)
        begin
            out_reg <= res_reg;
        end
    end

    assign status.out_full = valid_reg && !out_ready;
    assign out_axis        = out_reg;
    assign out_valid       = valid_reg;

endmodule

/* hw/rtl/three_axis_rate_pid_top.sv */
// Three-axis rate PID controller, top level.
// A control step walks each axis through error, integral, bit-serial derivative division
// (NW = RATE_WIDTH + 22 divider bits) and the three gain terms on the shared 24x24
// multiplier (NCH chunks). A clear command goes straight to publishing its zero result.
// No new input is taken until the previous result has moved to the output register.
// Reset (rst_n low) clears state and restores the gain values.
module three_axis_rate_pid_top #(
    parameter int RATE_WIDTH     = 32,
    parameter int INTEGRAL_WIDTH = 48,
    localparam int IN_W  = ((6 * RATE_WIDTH + rpid_pkg::DT_W + 7) / 8) * 8,
    localparam int OUT_W = ((3 * RATE_WIDTH + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // desired_roll, desired_pitch, desired_yaw, measured_roll, measured_pitch,
    // measured_yaw, step_period
    input  logic [IN_W-1:0]                   s_tdata,
    // command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_roll, out_pitch, out_yaw
    output logic [OUT_W-1:0]                  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpid_pkg::GAIN_W-1:0]       cfg_data
);

    localparam int RW  = RATE_WIDTH;
    localparam int MW0 = (RW + 1 > INTEGRAL_WIDTH) ? RW + 1 : INTEGRAL_WIDTH;
    localparam int MW  = (MW0 > rpid_pkg::CLAMP_W) ? MW0 : rpid_pkg::CLAMP_W;
    localparam int NCH = (MW + rpid_pkg::GAIN_W - 1) / rpid_pkg::GAIN_W;
    localparam int NW  = RW + 2 + rpid_pkg::DT_FRAC;

    logic [rpid_pkg::GAIN_W-1:0] gain_reg [rpid_pkg::NUM_GAINS];
    logic signed [RW-1:0]        des      [3];
    logic signed [RW-1:0]        meas     [3];
    logic signed [RW-1:0]        out_axis [3];
    rpid_pkg::rpid_cmd_t         cmd;
    rpid_pkg::rpid_status_t      status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= rpid_pkg::GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            // indexes beyond the gain list drop the transfer
            for (int i = 0; i < rpid_pkg::NUM_GAINS; i++)
            begin
                if (cfg_index == rpid_pkg::CFG_IDX_W'(i))
                begin
                    gain_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            des[i]  = s_tdata[i * RW +: RW];
            meas[i] = s_tdata[(i + 3) * RW +: RW];
        end
    end

    rpid_ctrl #(
        .NCH (NCH),
        .NW  (NW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rpid_dp #(
        .RW  (RW),
        .IW  (INTEGRAL_WIDTH),
        .NCH (NCH),
        .NW  (NW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .des_in    (des),
        .meas_in   (meas),
        .dt_in     (s_tdata[6 * RW +: rpid_pkg::DT_W]),
        .gain      (gain_reg),
        .out_axis  (out_axis),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = OUT_W'({out_axis[2], out_axis[1], out_axis[0]});

endmodule

/* sim/testbench.sv */
// Self-checking testbench for three_axis_rate_pid_top: streams control steps and clears,
// predicts each roll/pitch/yaw drive in fixed point and checks every output transfer.
// Depends on rpid_pkg and the three_axis_rate_pid_top RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int RATE_W = 32;
    localparam int IN_W   = ((6 * RATE_W + rpid_pkg::DT_W + 7) / 8) * 8;
    localparam int OUT_W  = ((3 * RATE_W + 7) / 8) * 8;
    localparam int LIMIT  = 2_000_000;
    localparam int DRAIN  = 240;

    typedef enum bit {CMD_STEP, CMD_CLEAR} pid_cmd_t;
    typedef enum logic [rpid_pkg::CFG_IDX_W-1:0] {
        REG_KP_RP, REG_KI_RP, REG_KD_RP, REG_KP_YAW, REG_KI_YAW, REG_KD_YAW,
        REG_SPARE6, REG_SPARE7
    } gain_reg_t;

    typedef struct {
        pid_cmd_t                    cmd;
        logic signed [RATE_W-1:0]    want [3];
        logic signed [RATE_W-1:0]    meas [3];
        logic [rpid_pkg::DT_W-1:0]   dt;
    } rate_step_t;

    typedef struct {
        logic signed [RATE_W-1:0] drive [3];
    } drive_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [rpid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rpid_pkg::GAIN_W-1:0] cfg_data = '0;

    three_axis_rate_pid_top dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // predictor state
    logic [rpid_pkg::GAIN_W-1:0] gain [rpid_pkg::NUM_GAINS];
    longint integ [3];
    longint prev_err [3];

    rate_step_t pending [$];
    drive_t     drives_due [$];
    int  mismatches = 0;
    int  failures = 0;
    int  results_seen = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;
    bit  idle_on = 1;
    longint cycles = 0;

    function automatic longint clamp_s(longint x, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    function automatic longint integ_inc(longint e, longint dt);
        longint eh, el;
        eh = e >>> rpid_pkg::DT_FRAC;
        el = e - (eh <<< rpid_pkg::DT_FRAC);
        return eh * dt + ((el * dt + (64'sd1 <<< (rpid_pkg::DT_FRAC - 1)))
                          >>> rpid_pkg::DT_FRAC);
    endfunction

    function automatic longint rate_deriv(longint diff, longint dt);
        longint mag, qh, q;
        if (dt == 0)
            return 0;
        mag = diff < 0 ? -diff : diff;
        qh = mag / dt;
        if (qh >= (64'sd1 <<< (47 - rpid_pkg::DT_FRAC)))
            q = 64'sd1 <<< 47;
        else
            q = (qh <<< rpid_pkg::DT_FRAC)
                + (((mag % dt) <<< rpid_pkg::DT_FRAC) + (dt >>> 1)) / dt;
        if (q > (64'sd1 <<< 47))
            q = 64'sd1 <<< 47;
        return diff < 0 ? -q : q;
    endfunction

    function automatic longint gain_term(longint a, logic [rpid_pkg::GAIN_W-1:0] k);
        bit [63:0] mag, p, t;
        mag = a < 0 ? 64'(-a) : 64'(a);
        if (k != 0 && mag > 64'h8000_0000_0000_0000 / 64'(k))
            t = 64'(rpid_pkg::TERM_CLAMP);
        else
        begin
            p = mag * 64'(k);
            t = a < 0 ? (p + 64'd32767) >> rpid_pkg::GAIN_FRAC
                      : (p + 64'd32768) >> rpid_pkg::GAIN_FRAC;
            if (t > 64'(rpid_pkg::TERM_CLAMP))
                t = 64'(rpid_pkg::TERM_CLAMP);
        end
        return a < 0 ? -longint'(t) : longint'(t);
    endfunction

    function automatic drive_t predict_drive(rate_step_t it);
        drive_t r;
        longint e, d, s;
        int g;
        for (int ax = 0; ax < 3; ax++)
        begin
            if (it.cmd == CMD_CLEAR)
            begin
                integ[ax] = 0;
                prev_err[ax] = 0;
                r.drive[ax] = '0;
            end
            else
            begin
                g = (ax == 2) ? int'(REG_KP_YAW) : int'(REG_KP_RP);
                e = longint'(it.want[ax]) - longint'(it.meas[ax]);
                integ[ax] = clamp_s(integ[ax] + integ_inc(e, longint'(it.dt)), 48);
                d = rate_deriv(e - prev_err[ax], longint'(it.dt));
                s = gain_term(e, gain[g]) + gain_term(integ[ax], gain[g + 1])
                    + gain_term(d, gain[g + 2]);
                r.drive[ax] = RATE_W'(clamp_s(s, RATE_W));
                prev_err[ax] = e;
            end
        end
        return r;
    endfunction

    // driver: one pending item offered per transfer, random gap after each while idle_on is set
    int tx_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                drives_due.push_back(predict_drive(pending.pop_front()));
                tx_gap = idle_on ? $urandom_range(0, 18) : 0;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 0;
                end
                else if (pending.size() > 0)
                begin
                    s_tvalid <= 1;
                    s_tuser  <= pending[0].cmd;
                    s_tdata  <= {4'b0, pending[0].dt,
                                 pending[0].meas[2], pending[0].meas[1], pending[0].meas[0],
                                 pending[0].want[2], pending[0].want[1], pending[0].want[0]};
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // long receiver hold-off, once, so the block backs up onto its input
    always @(posedge clk)
    begin
        if (!hold_done && results_seen == 60)
        begin
            hold_cnt  <= 2000;
            hold_done <= 1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor: compare each output transfer with the oldest predicted drive
    int rx_wait = 0;
    always @(posedge clk)
    begin
        drive_t want_d;
        logic signed [RATE_W-1:0] got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (drives_due.size() == 0)
                begin
                    failures++;
                    if (mismatches++ < 10)
                        $display("unexpected output transfer %h", m_tdata);
                end
                else
                begin
                    want_d = drives_due.pop_front();
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        got = m_tdata[ax * RATE_W +: RATE_W];
                        if (got !== want_d.drive[ax])
                        begin
                            failures++;
                            if (mismatches++ < 10)
                                $display("axis %0d drive: expected %0d, got %0d",
                                         ax, want_d.drive[ax], got);
                        end
                    end
                end
                rx_wait = idle_on ? $urandom_range(0, 18) : 0;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 0;
            end
            else
                m_tready <= (hold_cnt == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_gain(input gain_reg_t idx, input logic [rpid_pkg::GAIN_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx < rpid_pkg::NUM_GAINS)
            gain[idx] = val;
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || s_tvalid || drives_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_step(pid_cmd_t cmd, logic signed [RATE_W-1:0] w0, w1, w2,
                             m0, m1, m2, logic [rpid_pkg::DT_W-1:0] dt);
        rate_step_t it;
        it.cmd = cmd;
        it.want = '{w0, w1, w2};
        it.meas = '{m0, m1, m2};
        it.dt = dt;
        pending.push_back(it);
    endtask

    function automatic logic signed [RATE_W-1:0] rand_rate();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 400000) - 200000;
        endcase
    endfunction

    function automatic logic [rpid_pkg::DT_W-1:0] rand_dt();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return 20'd1;
            2: return 20'hFFFFF;
            3: return $urandom;
            default: return $urandom_range(500, 20000);
        endcase
    endfunction

    task automatic random_phase(int n);
        @(negedge clk);
        for (int i = 0; i < n; i++)
            push_step($urandom_range(0, 24) == 0 ? CMD_CLEAR : CMD_STEP,
                      rand_rate(), rand_rate(), rand_rate(),
                      rand_rate(), rand_rate(), rand_rate(), rand_dt());
    endtask

    localparam logic signed [RATE_W-1:0] RMAX = 32'h7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RMIN = 32'h8000_0000;

    initial
    begin
        for (int i = 0; i < rpid_pkg::NUM_GAINS; i++)
            gain[i] = rpid_pkg::GAIN_RESET[i];
        for (int i = 0; i < 3; i++)
        begin
            integ[i] = 0;
            prev_err[i] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, clears, zero and extreme step periods
        push_step(CMD_CLEAR, RMAX, RMIN, RMAX, RMIN, RMAX, RMIN, 20'hFFFFF);
        push_step(CMD_STEP, 0, 0, 0, 0, 0, 0, 20'd1049);
        push_step(CMD_STEP, RMAX, RMAX, RMAX, RMIN, RMIN, RMIN, 20'hFFFFF);
        push_step(CMD_STEP, RMIN, RMIN, RMIN, RMAX, RMAX, RMAX, 20'hFFFFF);
        push_step(CMD_STEP, RMAX, RMIN, 0, RMIN, RMAX, 0, 20'd1);
        push_step(CMD_STEP, 32'sh10000, -32'sh10000, 32'sh8000, 0, 0, 0, 20'd0);
        push_step(CMD_STEP, 32'sh10000, -32'sh10000, 32'sh8000, 0, 0, 0, 20'd0);
        push_step(CMD_STEP, -1, 1, -1, 0, 0, 0, 20'd1);
        push_step(CMD_STEP, RMAX, RMAX, RMAX, RMAX, RMAX, RMAX, 20'd1);
        push_step(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 20'd0);
        push_step(CMD_STEP, 32'sh20000, 32'sh30000, -32'sh20000, 32'sh8000, 0, 0, 20'd1049);
        push_step(CMD_STEP, 32'sh20000, 32'sh30000, -32'sh20000, 32'sh8000, 0, 0, 20'd1049);
        push_step(CMD_STEP, RMIN, RMAX, RMIN, RMIN, RMAX, RMIN, 20'h80000);
        push_step(CMD_STEP, 32'sh7, -32'sh7, 32'sh3, 0, 0, 0, 20'hFFFFF);
        for (int i = 0; i < 6; i++)
            push_step(CMD_STEP, RMAX, RMAX, RMAX, RMIN, RMIN, RMIN, 20'hFFFFF);
        wait_idle();

        for (int i = 0; i < rpid_pkg::NUM_GAINS; i++)
            write_gain(gain_reg_t'(i), 24'hFFFFFF);
        write_gain(REG_SPARE6, 24'h123456);
        write_gain(REG_SPARE7, 24'hFFFFFF);
        random_phase(300);
        wait_idle();

        for (int i = 0; i < rpid_pkg::NUM_GAINS; i++)
            write_gain(gain_reg_t'(i), '0);
        idle_on = 0;
        random_phase(200);
        wait_idle();
        idle_on = 1;

        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < rpid_pkg::NUM_GAINS; i++)
                write_gain(gain_reg_t'(i), p == 0 ? 24'($urandom)
                                                  : 24'($urandom_range(0, 24'h40000)));
            random_phase(330);
            wait_idle();
        end

        repeat (DRAIN) @(posedge clk);
        if (failures == 0 && drives_due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
